### rtl/same_channel_hit_time_merger_unit_assert.svh
// assertion macros used by the checker file
`ifndef SAME_CHANNEL_HIT_TIME_MERGER_UNIT_ASSERT_SVH
`define SAME_CHANNEL_HIT_TIME_MERGER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SCHM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define SCHM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/schm_pkg.sv
// ----------------------------------------------------------------------------
// schm_pkg
// Shared types and constants of the same-channel hit time merger.
// ----------------------------------------------------------------------------
`default_nettype none
package schm_pkg;
  localparam int HIT_DEPTH = 64;
  localparam int CNT_W = $clog2(HIT_DEPTH + 1);
  localparam int ESUM_W = 24;
  localparam int TSUM_W = 48;
  localparam logic [15:0] WINDOW_RST = 16'd272;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // one stored hit as it moves along the cell row
  typedef struct packed {
    logic                     used;
    logic [6:0]               channel;
    logic [ESUM_W-1:0]        esum;
    logic signed [TSUM_W-1:0] tsum;
  } hit_t;

  // digit broadcast to every cell
  typedef struct packed {
    logic              add;
    logic              clear;
    logic              shift;
    logic [6:0]        channel;
    logic signed [15:0] t;
    logic [15:0]       e;
    logic [15:0]       window;
  } bcast_t;
endpackage
`default_nettype wire

### rtl/same_channel_hit_time_merger_unit.sv
// Digit beat: operands latch, products register, then merge/accumulate in the
// cells.
// Flush: each hit shifts out of cell 0 and passes the 48-step divider, then
// waits for the output to be taken; an empty flush gives one beat.
// Sync active-low reset empties the table, clears overflow, window = 272.
// ----------------------------------------------------------------------------
// same_channel_hit_time_merger_unit
// Row of hit cells with shared divider for the flush drain.
// ----------------------------------------------------------------------------
`default_nettype none
module same_channel_hit_time_merger_unit import schm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_merge_window,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [6:0]        in_digit_channel,
  input  wire logic signed [15:0] in_digit_time,
  input  wire logic [15:0]       in_digit_energy,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit_valid,
  output logic [6:0]             out_out_channel,
  output logic [23:0]            out_out_energy,
  output logic signed [15:0]     out_out_time,
  output logic                   out_time_valid,
  output logic                   out_table_overflow,
  output logic                   out_last
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CMP, S_DRAIN, S_DIV, S_OUT} state_t;
  state_t state_r;
  logic [15:0] win_r;
  logic [CNT_W-1:0] cnt_r;
  logic drop_r;
  logic [6:0] ch_r;
  logic signed [15:0] t_r;
  logic [15:0] e_r;
  logic div_start;
  logic div_done;
  logic signed [15:0] quot;
  hit_t cur_r;
  bcast_t bc;
  hit_t hits [HIT_DEPTH];
  logic [HIT_DEPTH-1:0] m;

  assign in_ready = (state_r == S_IDLE);
  assign bc.add = (state_r == S_CMP);
  assign bc.clear = 1'b0;
  assign bc.shift = (state_r == S_DRAIN);
  assign bc.channel = ch_r;
  assign bc.t = t_r;
  assign bc.e = e_r;
  assign bc.window = win_r;

  // cell row, cell 0 drains first
  for (genvar g = 0; g < HIT_DEPTH; g++) begin : g_cell
    hit_t nb;
    if (g == HIT_DEPTH - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = hits[g+1];
    end
    schm_cell u_cell (
      .clk(clk), .rst_n(rst_n), .bc(bc), .prev_hit(nb),
      .open_here(bc.add && (m == '0) && (cnt_r == CNT_W'(g))),
      .hit(hits[g]), .match(m[g])
    );
  end

  assign div_start = (state_r == S_DRAIN);
  schm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(hits[0].tsum),
    .den(hits[0].esum), .done(div_done), .quot(quot)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r <= WINDOW_RST;
      cnt_r <= '0;
      drop_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) win_r <= cfg_merge_window;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ch_r <= in_digit_channel;
            t_r <= in_digit_time;
            e_r <= in_digit_energy;
            if (in_opcode == OP_ADD) begin
              state_r <= S_MUL;
            end else if (cnt_r == '0) begin
              out_valid <= 1'b1;
              out_hit_valid <= 1'b0;
              out_out_channel <= '0;
              out_out_energy <= '0;
              out_out_time <= '0;
              out_time_valid <= 1'b0;
              out_table_overflow <= drop_r;
              out_last <= 1'b1;
              drop_r <= 1'b0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_DRAIN;
            end
          end
        end
        // cells register their products from the latched digit
        S_MUL: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (m == '0) begin
            if (cnt_r == CNT_W'(HIT_DEPTH)) drop_r <= 1'b1;
            else cnt_r <= cnt_r + 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_DRAIN: begin
          cur_r <= hits[0];
          cnt_r <= cnt_r - 1'b1;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_valid <= 1'b1;
            out_hit_valid <= 1'b1;
            out_out_channel <= cur_r.channel;
            out_out_energy <= cur_r.esum;
            out_out_time <= (cur_r.esum == '0) ? 16'sd0 : quot;
            out_time_valid <= (cur_r.esum != '0);
            out_table_overflow <= drop_r;
            out_last <= (cnt_r == '0);
            if (cnt_r == '0) drop_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= (out_last) ? S_IDLE : S_DRAIN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/schm_cell.sv
// ----------------------------------------------------------------------------
// schm_cell
// One table cell: merge test and accumulate, plus shift towards the drain.
// ----------------------------------------------------------------------------
`default_nettype none
module schm_cell import schm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire bcast_t bc,
  input  wire hit_t   prev_hit,
  input  wire logic   open_here,
  output hit_t        hit,
  output logic        match
);
  hit_t hit_r, hit_nxt;
  logic signed [TSUM_W+1:0] te_r, lim_r, te2;
  logic signed [TSUM_W+1:0] diff;
  logic signed [TSUM_W+1:0] tsum_sum;
  logic [2:0]               tsum_top;
  logic [ESUM_W:0]          esum_sum;
  logic signed [32:0]       te_d;

  assign hit = hit_r;
  assign te_d = bc.t * $signed({1'b0, bc.e});

  // stage one: products registered; compare uses them
  always_ff @(posedge clk) begin
    te_r  <= (TSUM_W+2)'(bc.t * $signed({1'b0, hit_r.esum}));
    lim_r <= (TSUM_W+2)'($signed({1'b0, 40'(bc.window) * 40'(hit_r.esum)}));
  end

  always_comb begin
    diff = (TSUM_W+2)'(hit_r.tsum) - te_r;
    te2 = diff[TSUM_W+1] ? -diff : diff;
    match = bc.add && hit_r.used && (hit_r.channel == bc.channel) &&
            (bc.window != 16'd0) && (te2 < lim_r);
    esum_sum = {1'b0, hit_r.esum} + {{(ESUM_W-16+1){1'b0}}, bc.e};
    tsum_sum = (TSUM_W+2)'(hit_r.tsum) + (TSUM_W+2)'(te_d);
    tsum_top = tsum_sum[TSUM_W+1:TSUM_W-1];
    hit_nxt = hit_r;
    if (bc.clear) begin
      hit_nxt.used = 1'b0;
    end else if (bc.shift) begin
      hit_nxt = prev_hit;
    end else if (match) begin
      hit_nxt.esum = esum_sum[ESUM_W] ? '1 : esum_sum[ESUM_W-1:0];
      // saturate the weighted time sum to the signed 48-bit range
      if (tsum_top inside {3'b000, 3'b111})
        hit_nxt.tsum = tsum_sum[TSUM_W-1:0];
      else if (tsum_sum[TSUM_W+1])
        hit_nxt.tsum = {1'b1, {(TSUM_W-1){1'b0}}};
      else
        hit_nxt.tsum = {1'b0, {(TSUM_W-1){1'b1}}};
    end else if (open_here) begin
      hit_nxt.used = 1'b1;
      hit_nxt.channel = bc.channel;
      hit_nxt.esum = {{(ESUM_W-16){1'b0}}, bc.e};
      hit_nxt.tsum = TSUM_W'(te_d);
    end
  end

  // cell storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r.used <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/schm_div.sv
// ----------------------------------------------------------------------------
// schm_div
// Restoring divider, one quotient bit a cycle, truncating and saturating.
// ----------------------------------------------------------------------------
`default_nettype none
module schm_div import schm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [TSUM_W-1:0] num,
  input  wire logic [ESUM_W-1:0]        den,
  output logic                          done,
  output logic signed [15:0]            quot
);
  localparam int STEP_W = $clog2(TSUM_W + 1);
  logic [TSUM_W-1:0] q_r, q_nxt;
  logic [ESUM_W:0]   rem_r, rem_nxt;
  logic [ESUM_W-1:0] den_r;
  logic              neg_r, busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic [ESUM_W:0]   trial;
  logic [TSUM_W:0]   mag;

  // one shift-subtract step
  always_comb begin
    trial = {rem_r[ESUM_W-1:0], q_r[TSUM_W-1]};
    q_nxt = {q_r[TSUM_W-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
    mag = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
    if (!neg_r && q_r > TSUM_W'(32767)) quot = 16'sd32767;
    else if (neg_r && q_r > TSUM_W'(32768)) quot = -16'sd32768;
    else quot = mag[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= STEP_W'(TSUM_W);
        neg_r <= num[TSUM_W-1];
        q_r <= num[TSUM_W-1] ? -num : num;
        rem_r <= '0;
        den_r <= den;
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/schm_checker.sv
// ----------------------------------------------------------------------------
// schm_checker
// Port-level checks on the merger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "same_channel_hit_time_merger_unit_assert.svh"
module schm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_hit_valid,
  input wire logic out_time_valid,
  input wire logic out_last
);
  // an empty-event beat is always the last
  `SCHM_ASSERT_IMP(a_empty_last, out_valid && !out_hit_valid, out_last, "empty not last")
  // time valid only on a real hit
  `SCHM_ASSERT_IMP(a_tv_hit, out_valid && out_time_valid, out_hit_valid, "time_valid no hit")
  // no input taken while a result waits
  `SCHM_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken during output")
  // stalled output stays valid
  `SCHM_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid, "output dropped")
endmodule
bind same_channel_hit_time_merger_unit schm_checker u_chk (.*);
`default_nettype wire
